// ===== rtl/core/fpga_config_load_supervisor_unit_assert.svh =====
// Assertion macros used by the supervisor checker.
`ifndef FPGA_CONFIG_LOAD_SUPERVISOR_UNIT_ASSERT_SVH
`define FPGA_CONFIG_LOAD_SUPERVISOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCLS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FCLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fcls_pkg.sv =====
// Types, codes and helpers of the FPGA configuration load supervisor.
package fcls_pkg;

    // APB address width: five 32-bit registers at 4*i
    localparam int PADDR_W = 5;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] REG_LOAD_TIMEOUT   = 3'd0;
    localparam logic [2:0] REG_DETECT_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_ERROR_HOLD     = 3'd2;
    localparam logic [2:0] REG_POLL_INTERVAL  = 3'd3;
    localparam logic [2:0] REG_DONE_PIN_FIT   = 3'd4;

    // Register reset values
    localparam logic [31:0] LOAD_TIMEOUT_RST   = 32'd5000;
    localparam logic [31:0] DETECT_TIMEOUT_RST = 32'd100;
    localparam logic [31:0] ERROR_HOLD_RST     = 32'd1000;
    localparam logic [31:0] POLL_INTERVAL_RST  = 32'd1000;

    // Reported state codes
    localparam logic [2:0] SUP_STANDBY = 3'd0;
    localparam logic [2:0] SUP_LOAD    = 3'd1;
    localparam logic [2:0] SUP_RESET   = 3'd2;
    localparam logic [2:0] SUP_RUN     = 3'd3;
    localparam logic [2:0] SUP_PAUSE   = 3'd4;
    localparam logic [2:0] SUP_ERROR   = 3'd5;

    // Event codes
    localparam logic [2:0] EV_NONE           = 3'd0;
    localparam logic [2:0] EV_LOADED         = 3'd1;
    localparam logic [2:0] EV_LOAD_TIMEOUT   = 3'd2;
    localparam logic [2:0] EV_DETECT_TIMEOUT = 3'd3;
    localparam logic [2:0] EV_XFER_ERROR     = 3'd4;

    // Supervisor state, one-hot
    typedef enum logic [5:0] {
        ST_STANDBY = 6'b000001,
        ST_LOAD    = 6'b000010,
        ST_RESET   = 6'b000100,
        ST_RUN     = 6'b001000,
        ST_PAUSE   = 6'b010000,
        ST_ERROR   = 6'b100000
    } t_sup_state;

    // Poll request
    typedef struct packed {
        logic [31:0] now_tick;
        logic        power_enable;
        logic        core_power_ok;
        logic        init_b_pin;
        logic        done_pin;
        logic        detect_ok;
        logic        update_ok;
    } t_req;

    // Poll result
    typedef struct packed {
        logic [2:0]  sup_state;
        logic        interface_on;
        logic        interface_changed;
        logic        clear_record;
        logic        mark_fail;
        logic [2:0]  event_code;
        logic [31:0] load_ticks;
    } t_rsp;

    // Configuration seen by the step logic
    typedef struct packed {
        logic [31:0] load_timeout;
        logic [31:0] error_hold;
        logic [31:0] poll_interval;
        logic        done_pin_fitted;
        logic [32:0] detect_limit;  // detect timeout, plus load timeout when pins absent
    } t_cfg;

    // Supervisor context carried from poll to poll
    typedef struct packed {
        t_sup_state  state;
        logic [31:0] entry_tick;
        logic [31:0] load_start_tick;
        logic        level_known;
        logic        last_level;
    } t_ctx;

    localparam t_ctx CTX_RESET = '{
        state:           ST_STANDBY,
        entry_tick:      32'd0,
        load_start_tick: 32'd0,
        level_known:     1'b0,
        last_level:      1'b0
    };

    // One-hot state to reported code
    function automatic logic [2:0] state_code(input t_sup_state st);
        logic [2:0] code;
        code = SUP_STANDBY;
        case (st)
            ST_STANDBY: code = SUP_STANDBY;
            ST_LOAD:    code = SUP_LOAD;
            ST_RESET:   code = SUP_RESET;
            ST_RUN:     code = SUP_RUN;
            ST_PAUSE:   code = SUP_PAUSE;
            ST_ERROR:   code = SUP_ERROR;
            default:    code = SUP_STANDBY;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/core/fpga_config_load_supervisor_unit.sv =====
// FPGA configuration load supervisor: top level with request and result pipeline.
//
// Usage:
//   Poll requests enter on i_in_valid / o_in_ready / i_in_req; each carries a tick
//   count, power flags, INIT_B and DONE levels and the detect and update verdicts.
//   Every request yields exactly one result on o_out_valid / i_out_ready / o_out_rsp.
//   Registers sit behind an APB port: load timeout, detect timeout, error hold,
//   poll interval, DONE pin fitted, at byte addresses 0, 4, 8, 12, 16.
//   An accepted request waits in the input register and moves to the result register,
//   which offers it, when the result register is free or being emptied.
//   Throughput: one request per cycle while results are taken; the supervisor context
//   is updated in the same cycle that moves a request from the input register to the
//   result register. A stalled receiver holds the result; the input register still
//   takes one more request, after which o_in_ready drops until the result is taken.
//   Reset (synchronous, active low) empties both registers, puts the supervisor in
//   standby with zero tick marks and unknown DONE level, restores register defaults.
//   The user writes registers only while no request is in flight; not enforced here.
module fpga_config_load_supervisor_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // poll requests
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  fcls_pkg::t_req                i_in_req,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output fcls_pkg::t_rsp                o_out_rsp,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fcls_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    fcls_pkg::t_cfg cfg;
    fcls_pkg::t_ctx r_ctx;
    fcls_pkg::t_ctx n_ctx;
    fcls_pkg::t_req r_in_req;
    fcls_pkg::t_rsp r_out_rsp;
    fcls_pkg::t_rsp n_out_rsp;
    logic           r_in_vld;
    logic           r_out_vld;
    logic           advance;

    fcls_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fcls_step u_step (
        .i_req (r_in_req),
        .i_cfg (cfg),
        .i_ctx (r_ctx),
        .o_ctx (n_ctx),
        .o_rsp (n_out_rsp)
    );

    // Request moves on when the result register is free or being emptied
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_ctx     <= fcls_pkg::CTX_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_ctx     <= n_ctx;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_req <= i_in_req;
        end
        if (advance) begin
            r_out_rsp <= n_out_rsp;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_rsp   = r_out_rsp;

endmodule

// ===== rtl/core/fcls_cfg_regs.sv =====
// APB configuration registers and the precomputed detect limit.
module fcls_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fcls_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output fcls_pkg::t_cfg                o_cfg
);

    logic [31:0] r_load_timeout;
    logic [31:0] r_detect_timeout;
    logic [31:0] r_error_hold;
    logic [31:0] r_poll_interval;
    logic        r_done_pin_fitted;
    logic [32:0] detect_limit;
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[fcls_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_timeout    <= fcls_pkg::LOAD_TIMEOUT_RST;
            r_detect_timeout  <= fcls_pkg::DETECT_TIMEOUT_RST;
            r_error_hold      <= fcls_pkg::ERROR_HOLD_RST;
            r_poll_interval   <= fcls_pkg::POLL_INTERVAL_RST;
            r_done_pin_fitted <= 1'b1;
        end else if (wr_en) begin
            case (reg_idx)
                fcls_pkg::REG_LOAD_TIMEOUT:   r_load_timeout    <= pwdata;
                fcls_pkg::REG_DETECT_TIMEOUT: r_detect_timeout  <= pwdata;
                fcls_pkg::REG_ERROR_HOLD:     r_error_hold      <= pwdata;
                fcls_pkg::REG_POLL_INTERVAL:  r_poll_interval   <= pwdata;
                fcls_pkg::REG_DONE_PIN_FIT:   r_done_pin_fitted <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Detect limit, 33 bits so the sum cannot overflow; follows the registers directly
    assign detect_limit = {1'b0, r_detect_timeout}
                        + (r_done_pin_fitted ? 33'd0 : {1'b0, r_load_timeout});

    // Read-back mux
    always_comb begin
        case (reg_idx)
            fcls_pkg::REG_LOAD_TIMEOUT:   prdata = r_load_timeout;
            fcls_pkg::REG_DETECT_TIMEOUT: prdata = r_detect_timeout;
            fcls_pkg::REG_ERROR_HOLD:     prdata = r_error_hold;
            fcls_pkg::REG_POLL_INTERVAL:  prdata = r_poll_interval;
            fcls_pkg::REG_DONE_PIN_FIT:   prdata = {31'd0, r_done_pin_fitted};
            default:                      prdata = 32'd0;
        endcase
    end

    assign o_cfg.load_timeout    = r_load_timeout;
    assign o_cfg.error_hold      = r_error_hold;
    assign o_cfg.poll_interval   = r_poll_interval;
    assign o_cfg.done_pin_fitted = r_done_pin_fitted;
    assign o_cfg.detect_limit    = detect_limit;

endmodule

// ===== rtl/core/fcls_step.sv =====
// Per-poll decision logic: next context and the result of one request.
module fcls_step (
    input  fcls_pkg::t_req i_req,
    input  fcls_pkg::t_cfg i_cfg,
    input  fcls_pkg::t_ctx i_ctx,
    output fcls_pkg::t_ctx o_ctx,
    output fcls_pkg::t_rsp o_rsp
);

    logic                  fitted;
    logic                  initb;
    logic                  donep;
    logic                  power;
    logic                  enable;
    logic                  done;
    logic [31:0]           elapsed;
    logic [31:0]           since_load;
    logic                  changed;
    fcls_pkg::t_sup_state  next_st;
    logic [2:0]            event_code;
    logic [31:0]           lticks;
    logic                  take_start;

    // Pin qualification: absent pins read as high
    assign fitted     = i_cfg.done_pin_fitted;
    assign initb      = fitted ? i_req.init_b_pin : 1'b1;
    assign donep      = fitted ? i_req.done_pin : 1'b1;
    assign power      = i_req.power_enable && i_req.core_power_ok;
    assign enable     = power && initb;
    assign done       = power && donep;
    assign elapsed    = i_req.now_tick - i_ctx.entry_tick;
    assign since_load = i_req.now_tick - i_ctx.load_start_tick;
    assign changed    = !i_ctx.level_known || (i_ctx.last_level != done);

    // State transitions
    always_comb begin
        next_st    = i_ctx.state;
        event_code = fcls_pkg::EV_NONE;
        lticks     = 32'd0;
        take_start = 1'b0;
        case (i_ctx.state)
            fcls_pkg::ST_STANDBY: begin
                if (enable) begin
                    next_st    = fcls_pkg::ST_LOAD;
                    take_start = 1'b1;
                end
            end
            fcls_pkg::ST_LOAD: begin
                if (!enable) begin
                    next_st = fcls_pkg::ST_STANDBY;
                end else if (done) begin
                    if (fitted) begin
                        event_code = fcls_pkg::EV_LOADED;
                        lticks     = since_load;
                    end
                    next_st = fcls_pkg::ST_RESET;
                end else if (elapsed > i_cfg.load_timeout) begin
                    event_code = fcls_pkg::EV_LOAD_TIMEOUT;
                    next_st    = fcls_pkg::ST_ERROR;
                end
            end
            fcls_pkg::ST_RESET: begin
                if (!power) begin
                    next_st = fcls_pkg::ST_STANDBY;
                end else if ({1'b0, elapsed} > i_cfg.detect_limit) begin
                    // timeout wins over a detection on the same poll
                    event_code = fcls_pkg::EV_DETECT_TIMEOUT;
                    next_st    = fcls_pkg::ST_ERROR;
                end else if (i_req.detect_ok) begin
                    next_st = fcls_pkg::ST_RUN;
                    if (!fitted) begin
                        event_code = fcls_pkg::EV_LOADED;
                        lticks     = since_load;
                    end
                end
            end
            fcls_pkg::ST_RUN: begin
                if (!done) begin
                    next_st = fcls_pkg::ST_STANDBY;
                end else if (!i_req.update_ok) begin
                    event_code = fcls_pkg::EV_XFER_ERROR;
                    next_st    = fcls_pkg::ST_ERROR;
                end else begin
                    next_st = fcls_pkg::ST_PAUSE;
                end
            end
            fcls_pkg::ST_PAUSE: begin
                if (!done) begin
                    next_st = fcls_pkg::ST_STANDBY;
                end else if (elapsed > i_cfg.poll_interval) begin
                    next_st = fcls_pkg::ST_RUN;
                end
            end
            fcls_pkg::ST_ERROR: begin
                if (elapsed > i_cfg.error_hold) begin
                    next_st = fcls_pkg::ST_STANDBY;
                end
            end
            default: ;
        endcase
    end

    // Context update
    assign o_ctx.state           = next_st;
    assign o_ctx.entry_tick      = (next_st != i_ctx.state) ? i_req.now_tick
                                                            : i_ctx.entry_tick;
    assign o_ctx.load_start_tick = take_start ? i_req.now_tick : i_ctx.load_start_tick;
    assign o_ctx.level_known     = 1'b1;
    assign o_ctx.last_level      = done;

    // Result fields
    assign o_rsp.sup_state         = fcls_pkg::state_code(next_st);
    assign o_rsp.interface_on      = done;
    assign o_rsp.interface_changed = changed;
    assign o_rsp.clear_record      = (i_ctx.state == fcls_pkg::ST_STANDBY);
    assign o_rsp.mark_fail         = (i_ctx.state == fcls_pkg::ST_ERROR);
    assign o_rsp.event_code        = event_code;
    assign o_rsp.load_ticks        = lticks;

endmodule

// ===== rtl/core/fcls_checker.sv =====
// Port-level checker for the supervisor, bound to the top level.
`include "fpga_config_load_supervisor_unit_assert.svh"

module fcls_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input fcls_pkg::t_rsp o_out_rsp
);

    // stalled result holds
    `FCLS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_rsp), "result changed while stalled")

    // load time is reported only with the loaded event
    `FCLS_ASSERT_IMPLY(a_ticks_only_loaded, i_clk, i_rst_n, o_out_valid && (o_out_rsp.event_code != fcls_pkg::EV_LOADED), o_out_rsp.load_ticks == 32'd0, "load ticks without loaded event")

    // loaded event leaves the supervisor in reset or run
    `FCLS_ASSERT_IMPLY(a_loaded_state, i_clk, i_rst_n, o_out_valid && (o_out_rsp.event_code == fcls_pkg::EV_LOADED), (o_out_rsp.sup_state == fcls_pkg::SUP_RESET) || (o_out_rsp.sup_state == fcls_pkg::SUP_RUN), "loaded event in wrong state")

    // every failure event lands in error
    `FCLS_ASSERT_IMPLY(a_fail_to_error, i_clk, i_rst_n, o_out_valid && ((o_out_rsp.event_code == fcls_pkg::EV_LOAD_TIMEOUT) || (o_out_rsp.event_code == fcls_pkg::EV_DETECT_TIMEOUT) || (o_out_rsp.event_code == fcls_pkg::EV_XFER_ERROR)), o_out_rsp.sup_state == fcls_pkg::SUP_ERROR, "failure event without error state")

endmodule

bind fpga_config_load_supervisor_unit fcls_checker u_fcls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_rsp   (o_out_rsp)
);
